FILE: rtl/core/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the two-stacks-in-one-memory core.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Memory geometry
    localparam int STORE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Field widths
    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int STS_W   = 2;
    localparam int COUNT_W = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUSH_LOW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_HIGH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_LOW   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_HIGH  = 2'd3;

    // Result status codes
    localparam logic [STS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } dss_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // latch incoming item
        logic exec;     // perform push/pop on latched item
        logic capture;  // take RAM read data as pop result
    } dss_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic needs_read;  // latched item is a pop of a non-empty stack
    } dss_sts_t;

endpackage

FILE: rtl/core/dss_ram.sv
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer: accept item, execute, wait on RAM read for pops, hold result.
// ----------------------------------------------------------------------------
module dss_ctrl
    import dss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dss_sts_t sts,
    output dss_cmd_t cmd
);

    dss_state_t state_reg;
    dss_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.needs_read ? ST_READ : ST_RESP;
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_READ:
            begin
                cmd.capture = 1'b1;
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/dss_dp.sv
// ----------------------------------------------------------------------------
// dss_dp
// Datapath: item latch, stack counters, address select, shared RAM, result.
// ----------------------------------------------------------------------------
module dss_dp
    import dss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dss_cmd_t            cmd,
    output dss_sts_t            sts,
    input  logic [CMD_W-1:0]    in_command,
    input  logic [WORD_W-1:0]   in_value,
    output logic [WORD_W-1:0]   pop_value,
    output logic [STS_W-1:0]    status,
    output logic [COUNT_W-1:0]  low_count,
    output logic [COUNT_W-1:0]  high_count
);

    logic [CMD_W-1:0]  cmd_reg;
    logic [WORD_W-1:0] val_reg;
    logic [CNT_W-1:0]  low_cnt_reg;
    logic [CNT_W-1:0]  low_cnt_next;
    logic [CNT_W-1:0]  high_cnt_reg;
    logic [CNT_W-1:0]  high_cnt_next;
    logic [WORD_W-1:0] pop_value_reg;
    logic [WORD_W-1:0] pop_value_next;
    logic [STS_W-1:0]  status_reg;
    logic [STS_W-1:0]  status_next;

    logic [CNT_W:0]    used;
    logic              full;
    logic              low_empty;
    logic              high_empty;
    logic              is_push;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_rdata;

    assign used       = (CNT_W+1)'(low_cnt_reg) + (CNT_W+1)'(high_cnt_reg);
    assign full       = (used >= (CNT_W+1)'(STORE_DEPTH));
    assign low_empty  = (low_cnt_reg == '0);
    assign high_empty = (high_cnt_reg == '0);
    assign is_push    = (cmd_reg == CMD_PUSH_LOW) || (cmd_reg == CMD_PUSH_HIGH);

    // pop of a non-empty stack goes through the RAM read
    always_comb
    begin
        case (cmd_reg)
            CMD_POP_LOW:  sts.needs_read = !low_empty;
            CMD_POP_HIGH: sts.needs_read = !high_empty;
            default:      sts.needs_read = 1'b0;
        endcase
    end

    assign ram_we = cmd.exec && is_push && !full;
    assign ram_re = cmd.exec && sts.needs_read;

    // low stack grows up from 0, high stack grows down from the top entry
    always_comb
    begin
        case (cmd_reg)
            CMD_PUSH_LOW:  ram_addr = low_cnt_reg[ADDR_W-1:0];
            CMD_PUSH_HIGH: ram_addr = ADDR_W'(STORE_DEPTH - 1) - high_cnt_reg[ADDR_W-1:0];
            CMD_POP_LOW:   ram_addr = ADDR_W'(low_cnt_reg - CNT_W'(1));
            CMD_POP_HIGH:  ram_addr = ADDR_W'(STORE_DEPTH - 1)
                                      - ADDR_W'(high_cnt_reg - CNT_W'(1));
            default:       ram_addr = '0;
        endcase
    end

    dss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        low_cnt_next   = low_cnt_reg;
        high_cnt_next  = high_cnt_reg;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        if (cmd.exec)
        begin
            pop_value_next = '0;
            status_next    = STATUS_OK;
            case (cmd_reg)
                CMD_PUSH_LOW:
                begin
                    if (full)
                        status_next = STATUS_OVERFLOW;
                    else
                        low_cnt_next = low_cnt_reg + CNT_W'(1);
                end
                CMD_PUSH_HIGH:
                begin
                    if (full)
                        status_next = STATUS_OVERFLOW;
                    else
                        high_cnt_next = high_cnt_reg + CNT_W'(1);
                end
                CMD_POP_LOW:
                begin
                    if (low_empty)
                    begin
                        status_next    = STATUS_UNDERFLOW;
                        pop_value_next = '1;
                    end
                    else
                    begin
                        low_cnt_next = low_cnt_reg - CNT_W'(1);
                    end
                end
                CMD_POP_HIGH:
                begin
                    if (high_empty)
                    begin
                        status_next    = STATUS_UNDERFLOW;
                        pop_value_next = '1;
                    end
                    else
                    begin
                        high_cnt_next = high_cnt_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
        else if (cmd.capture)
        begin
            pop_value_next = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
        end
        else
        begin
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_command;
            val_reg <= in_value;
        end
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    assign pop_value  = pop_value_reg;
    assign status     = status_reg;
    assign low_count  = COUNT_W'(low_cnt_reg);
    assign high_count = COUNT_W'(high_cnt_reg);

endmodule

FILE: rtl/core/dual_stack_shared_memory_core.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_core
// Two LIFO stacks in one shared single-port word memory.
// ----------------------------------------------------------------------------
// One item in, one result out. The low stack fills the memory from entry 0
// upward, the high stack from the top entry downward; a push is refused with
// overflow status when both together fill the memory, and a pop of an empty
// stack gives -1 with underflow status. The core works on one item at a time:
// a push, a refused push or an empty pop goes from the execute state straight
// to the result state, a successful pop passes through an extra read state for
// the registered read of the single-port RAM, and the next item is accepted
// only after the result is taken and the core is back in its idle state.
// The counts in each result are the stack depths after the item.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_core
    import dss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] pop_value, [39:32] low_count,
                                   // [47:40] high_count
    output logic [1:0]  m_tuser    // [1:0] status
);

    dss_cmd_t           cmd;
    dss_sts_t           sts;
    logic [WORD_W-1:0]  pop_value;
    logic [STS_W-1:0]   status;
    logic [COUNT_W-1:0] low_count;
    logic [COUNT_W-1:0] high_count;

    // Sequencer
    dss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Counters, shared memory and result registers
    dss_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_command (s_tuser),
        .in_value   (s_tdata),
        .pop_value  (pop_value),
        .status     (status),
        .low_count  (low_count),
        .high_count (high_count)
    );

    // Result held in registers until taken
    assign m_tdata = {high_count, low_count, pop_value};
    assign m_tuser = status;

endmodule

FILE: rtl/core/dss_checker.sv
// ----------------------------------------------------------------------------
// dss_checker
// Port-level assertions for the dual stack core, bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker
    import dss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in flight: no intake while a result is shown
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while result pending");

    // an accepted item blocks further intake on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("intake not closed after accept");

    // underflow returns all ones
    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_UNDERFLOW) |-> (m_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("underflow result not -1");

    // overflow only when memory is full, and returns zero
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_OVERFLOW) |->
            (m_tdata[31:0] == 32'd0)
            && ((9'(m_tdata[39:32]) + 9'(m_tdata[47:40])) == 9'(STORE_DEPTH)))
        else $error("overflow result inconsistent");

endmodule

bind dual_stack_shared_memory_core dss_checker u_dss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
